FILE: src/rcf_pkg.sv
// Shared types and constants for the chunk framer.
`default_nettype none
package rcf_pkg;

  localparam int unsigned JobBytes = 18;               // longest byte run of one item
  localparam int unsigned CntW     = $clog2(JobBytes + 1);
  localparam int unsigned IdxW     = $clog2(JobBytes);

  localparam logic [23:0] TsEscape      = 24'hffffff;
  localparam logic [16:0] CsidTwoByte   = 17'd64;
  localparam logic [16:0] CsidThreeByte = 17'd64 + 17'd255;
  localparam logic [16:0] ChunkReset    = 17'd128;
  localparam logic [16:0] ChunkMax      = 17'd65536;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_PAYLOAD = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    FMT_FULL = 2'd0,
    FMT_CONT = 2'd3
  } fmt_e;

  // One queued job: bytes go out LSB entry first.
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     done;
  } job_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage
`default_nettype wire

FILE: src/rcf_front.sv
// Front end: accepts items, tracks message state, builds byte jobs.
`default_nettype none
module rcf_front import rcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [16:0] cfg_wr_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        q_full_i,
  input  wire logic        action_i,
  input  wire logic [16:0] chunk_stream_id_i,
  input  wire logic [31:0] msg_timestamp_i,
  input  wire logic [31:0] ext_timestamp_i,
  input  wire logic [23:0] msg_length_i,
  input  wire logic [7:0]  msg_type_i,
  input  wire logic [31:0] msg_stream_i,
  input  wire logic [7:0]  payload_byte_i,
  output logic             push_o,
  output job_t             job_o
);

  logic [16:0] chunk_lim_q;
  logic        open_q,  open_d;
  logic [23:0] rem_q,   rem_d;
  logic [16:0] bic_q,   bic_d;
  logic [16:0] csid_q,  csid_d;
  logic        ext_q,   ext_d;
  logic [31:0] ext_ts_q, ext_ts_d;

  logic        accept;
  logic [23:0] rem_dec;
  logic [16:0] bic_inc;
  logic [16:0] eff_chunk;
  logic        use_ext;
  logic [23:0] ts24;
  logic [23:0] bas_full, bas_cont;
  logic [1:0]  blen_full, blen_cont;
  logic [31:0] ext_rev_new, ext_rev_old;
  logic [119:0] hdr_tail;
  logic [55:0]  cont_seq;
  logic         is_last, ins_hdr;

  function automatic logic [25:0] basic_hdr(input logic [1:0] fmt, input logic [16:0] csid);
    logic [15:0] rel;
    logic [25:0] r;
    rel = 16'(csid - CsidTwoByte);
    if (csid >= CsidThreeByte) begin
      r = {2'd3, rel[15:8], rel[7:0], fmt, 6'd1};
    end else if (csid >= CsidTwoByte) begin
      r = {2'd2, 8'd0, rel[7:0], fmt, 6'd0};
    end else begin
      r = {2'd1, 16'd0, fmt, csid[5:0]};
    end
    return r;
  endfunction

  assign accept = in_valid_i && !q_full_i;

  assign {blen_full, bas_full} = basic_hdr(FMT_FULL, chunk_stream_id_i);
  assign {blen_cont, bas_cont} = basic_hdr(FMT_CONT, csid_q);

  assign use_ext = msg_timestamp_i >= {8'd0, TsEscape};
  assign ts24    = use_ext ? TsEscape : msg_timestamp_i[23:0];

  assign ext_rev_new = {ext_timestamp_i[7:0], ext_timestamp_i[15:8],
                        ext_timestamp_i[23:16], ext_timestamp_i[31:24]};
  assign ext_rev_old = {ext_ts_q[7:0], ext_ts_q[15:8], ext_ts_q[23:16], ext_ts_q[31:24]};

  // Message header after the basic header, first byte in the low bits.
  assign hdr_tail = {ext_rev_new, msg_stream_i, msg_type_i,
                     msg_length_i[7:0], msg_length_i[15:8], msg_length_i[23:16],
                     ts24[7:0], ts24[15:8], ts24[23:16]};

  always_comb begin
    case (blen_cont)
      2'd1:    cont_seq = {16'd0, ext_rev_old, bas_cont[7:0]};
      2'd2:    cont_seq = {8'd0, ext_rev_old, bas_cont[15:0]};
      default: cont_seq = {ext_rev_old, bas_cont};
    endcase
  end

  // Chunk size 0 acts as 1, anything above 64 KiB as 64 KiB.
  always_comb begin
    if (chunk_lim_q == 17'd0) begin
      eff_chunk = 17'd1;
    end else if (chunk_lim_q > ChunkMax) begin
      eff_chunk = ChunkMax;
    end else begin
      eff_chunk = chunk_lim_q;
    end
  end

  assign rem_dec = rem_q - 24'd1;
  assign bic_inc = bic_q + 17'd1;
  assign is_last = rem_dec == 24'd0;
  assign ins_hdr = !is_last && (bic_inc >= eff_chunk);

  always_comb begin
    open_d   = open_q;
    rem_d    = rem_q;
    bic_d    = bic_q;
    csid_d   = csid_q;
    ext_d    = ext_q;
    ext_ts_d = ext_ts_q;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept) begin
      if (action_e'(action_i) == ACT_START) begin
        push_o   = 1'b1;
        case (blen_full)
          2'd1:    job_o.bytes = {16'd0, hdr_tail, bas_full[7:0]};
          2'd2:    job_o.bytes = {8'd0, hdr_tail, bas_full[15:0]};
          default: job_o.bytes = {hdr_tail, bas_full};
        endcase
        job_o.cnt  = CntW'(blen_full) + CntW'(11) + (use_ext ? CntW'(4) : CntW'(0));
        job_o.done = msg_length_i == 24'd0;
        open_d   = msg_length_i != 24'd0;
        rem_d    = msg_length_i;
        bic_d    = '0;
        csid_d   = chunk_stream_id_i;
        ext_d    = use_ext;
        ext_ts_d = ext_timestamp_i;
      end else if (open_q) begin
        push_o      = 1'b1;
        job_o.bytes = {80'd0, cont_seq, payload_byte_i};
        job_o.cnt   = CntW'(1);
        if (ins_hdr) begin
          job_o.cnt = CntW'(1) + CntW'(blen_cont) + (ext_q ? CntW'(4) : CntW'(0));
        end
        job_o.done  = is_last;
        rem_d       = rem_dec;
        bic_d       = (is_last || ins_hdr) ? 17'd0 : bic_inc;
        open_d      = !is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_lim_q <= ChunkReset;
      open_q      <= 1'b0;
      rem_q       <= '0;
      bic_q       <= '0;
      csid_q      <= '0;
      ext_q       <= 1'b0;
      ext_ts_q    <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        chunk_lim_q <= cfg_wr_data_i;
      end
      open_q   <= open_d;
      rem_q    <= rem_d;
      bic_q    <= bic_d;
      csid_q   <= csid_d;
      ext_q    <= ext_d;
      ext_ts_q <= ext_ts_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/rcf_queue.sv
// Small job FIFO between front and back end.
`default_nettype none
module rcf_queue import rcf_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output logic      full_o,
  output head_t     head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [NumW-1:0] num_q, num_d;
  logic            do_push, do_pop;

  assign full_o       = num_q == NumW'(Depth);
  assign head_o.valid = num_q != '0;
  assign head_o.job   = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      num_d = num_q + NumW'(1);
    end else if (do_pop && !do_push) begin
      num_d = num_q - NumW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/rcf_back.sv
// Back end: walks the head job into the output register, one byte per cycle unless out_stall_i holds it.
`default_nettype none
module rcf_back import rcf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire head_t      head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            message_done_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            vld_q, vld_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            done_q, done_d;
  logic            load, at_end;

  assign load   = !vld_q || !out_stall_i;
  assign at_end = CntW'(idx_q) == head_i.job.cnt - CntW'(1);
  assign pop_o  = load && head_i.valid && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    done_d = done_q;
    if (load) begin
      vld_d  = head_i.valid;
      byte_d = head_i.job.bytes[idx_q];
      last_d = at_end;
      done_d = at_end && head_i.job.done;
      if (head_i.valid) begin
        idx_d = at_end ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o    = vld_q;
  assign out_byte_o     = byte_q;
  assign run_last_o     = last_q;
  assign message_done_o = done_q;

endmodule
`default_nettype wire

FILE: src/rtmp_chunk_framer_core.sv
// Top level of the chunk framer: front end, job queue, back end.
//
// Input channel (in_valid_i / in_stall_o): one transaction is either a
// message start (action 0, header fields) or one payload byte (action 1).
// Output channel (out_valid_o / out_stall_i): one transaction per byte of
// the chunked stream; run_last_o marks the last byte caused by an input
// transaction, message_done_o the final byte of a message.
// The first output byte passes through the job queue and then the output register.
// One byte per cycle out while out_stall_i is low (the back end's byte walk).
// A payload byte yields 1 byte, plus 1-3 basic header bytes and 0 or 4
// extended timestamp bytes at a chunk boundary; a start yields 12 to 18 bytes.
// The front end runs ahead of the back end by up to QueueDepth jobs, so
// plain payload streams at one byte per cycle while out_stall_i is low.
// Payload with no open message is taken and dropped. The user must write the
// chunk length limit through cfg_wr_en_i / cfg_wr_data_i only while idle; the
// block does not enforce it. Reset: no open message, empty queue, chunk
// length limit = 128. When out_stall_i is high the output register holds;
// the queue then fills and in_stall_o rises.
`default_nettype none
module rtmp_chunk_framer_core import rcf_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [16:0] cfg_wr_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [16:0] chunk_stream_id_i,
  input  wire logic [31:0] msg_timestamp_i,
  input  wire logic [31:0] ext_timestamp_i,
  input  wire logic [23:0] msg_length_i,
  input  wire logic [7:0]  msg_type_i,
  input  wire logic [31:0] msg_stream_i,
  input  wire logic [7:0]  payload_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             message_done_o
);

  logic  push, pop, q_full;
  job_t  job;
  head_t head;

  // Stall only on a full queue; dropped payload is still taken.
  assign in_stall_o = q_full;

  rcf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .q_full_i          (q_full),
    .action_i          (action_i),
    .chunk_stream_id_i (chunk_stream_id_i),
    .msg_timestamp_i   (msg_timestamp_i),
    .ext_timestamp_i   (ext_timestamp_i),
    .msg_length_i      (msg_length_i),
    .msg_type_i        (msg_type_i),
    .msg_stream_i      (msg_stream_i),
    .payload_byte_i    (payload_byte_i),
    .push_o            (push),
    .job_o             (job)
  );

  rcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  rcf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .message_done_o (message_done_o)
  );

endmodule
`default_nettype wire
